// File: hw/rtl/linear_key_value_table_top_assert.svh
// assertion macros for the key-value table
`ifndef LINEAR_KEY_VALUE_TABLE_TOP_ASSERT_SVH
`define LINEAR_KEY_VALUE_TABLE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LKVT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define LKVT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/lkvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lkvt_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [1:0] {
    KIND_GET    = 2'd0,
    KIND_SET    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic    load;
    logic    scan_step;
    logic    wr_hit;
    logic    append;
    logic    rd_last;
    logic    move_last;
    logic    clr;
    logic    post;
    logic    post_rd;
    status_t post_status;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  hit;
    logic  more;
    logic  room;
    logic  out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/lkvt_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lkvt_req_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [lkvt_pkg::KEY_W-1:0] key;
  logic [lkvt_pkg::VAL_W-1:0] value;

  modport source (output valid, output kind, output key, output value, input ready);
  modport sink (input valid, input kind, input key, input value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lkvt_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lkvt_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [lkvt_pkg::VAL_W-1:0] read_value;
  logic [lkvt_pkg::CNT_W-1:0] entry_count;

  modport source (output valid, output status, output read_value, output entry_count,
                  input ready);
  modport sink (input valid, input status, input read_value, input entry_count,
                output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lkvt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lkvt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               valid,
  output logic                    ready,
  input  wire lkvt_pkg::dp_stat_t stat,
  output lkvt_pkg::dp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RM_RD,
    S_RM_WR,
    S_POST
  } state_t;

  state_t            state;
  lkvt_pkg::status_t res_status;
  logic              res_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ready      <= 1'b1;
      res_status <= lkvt_pkg::ST_OK;
      res_rd     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (valid) begin
            state  <= S_SCAN;
            ready  <= 1'b0;
            res_rd <= 1'b0;
          end
        end
        S_SCAN: begin
          priority if (stat.kind == lkvt_pkg::KIND_CLEAR) begin
            res_status <= lkvt_pkg::ST_OK;
            state      <= S_POST;
          end else if (stat.hit) begin
            res_status <= lkvt_pkg::ST_OK;
            res_rd     <= (stat.kind == lkvt_pkg::KIND_GET);
            state      <= (stat.kind == lkvt_pkg::KIND_REMOVE) ? S_RM_RD : S_POST;
          end else if (stat.more) begin
            state <= S_SCAN;
          end else begin
            // scan ran out without a match
            priority if (stat.kind != lkvt_pkg::KIND_SET) begin
              res_status <= lkvt_pkg::ST_NOT_FOUND;
            end else if (stat.room) begin
              res_status <= lkvt_pkg::ST_OK;
            end else begin
              res_status <= lkvt_pkg::ST_FULL;
            end
            state <= S_POST;
          end
        end
        S_RM_RD: state <= S_RM_WR;
        S_RM_WR: state <= S_POST;
        S_POST: begin
          if (stat.out_free) begin
            state <= S_IDLE;
            ready <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.post_status = res_status;
    cmd.post_rd     = res_rd;
    unique case (state)
      S_IDLE: cmd.load = valid;
      S_SCAN: begin
        priority if (stat.kind == lkvt_pkg::KIND_CLEAR) begin
          cmd.clr = 1'b1;
        end else if (stat.hit) begin
          cmd.wr_hit = (stat.kind == lkvt_pkg::KIND_SET);
        end else if (stat.more) begin
          cmd.scan_step = 1'b1;
        end else begin
          cmd.append = (stat.kind == lkvt_pkg::KIND_SET) && stat.room;
        end
      end
      S_RM_RD: cmd.rd_last = 1'b1;
      S_RM_WR: cmd.move_last = 1'b1;
      S_POST:  cmd.post = stat.out_free;
      default: cmd.load = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/lkvt_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module lkvt_dpath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire lkvt_pkg::dp_cmd_t            cmd,
  output lkvt_pkg::dp_stat_t                stat,
  input  wire logic [1:0]                   in_kind,
  input  wire logic [lkvt_pkg::KEY_W-1:0]   in_key,
  input  wire logic [lkvt_pkg::VAL_W-1:0]   in_value,
  input  wire logic                         cfg_we,
  input  wire logic [lkvt_pkg::CAP_W-1:0]   cfg_wdata,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        out_status,
  output logic [lkvt_pkg::VAL_W-1:0]        out_read_value,
  output logic [lkvt_pkg::CNT_W-1:0]        out_entry_count
);

  logic [lkvt_pkg::KEY_W-1:0] key_mem [lkvt_pkg::DEPTH];
  logic [lkvt_pkg::VAL_W-1:0] val_mem [lkvt_pkg::DEPTH];

  lkvt_pkg::kind_t            req_kind;
  logic [lkvt_pkg::KEY_W-1:0] req_key;
  logic [lkvt_pkg::VAL_W-1:0] req_value;

  logic [lkvt_pkg::CNT_W-1:0] count;
  logic [lkvt_pkg::CAP_W-1:0] cap;
  logic [lkvt_pkg::CNT_W-1:0] scan_idx;
  logic [lkvt_pkg::IDX_W-1:0] chk_idx;
  logic                       chk_vld;
  logic [lkvt_pkg::KEY_W-1:0] rd_key;
  logic [lkvt_pkg::VAL_W-1:0] rd_val;

  logic                       rd_en;
  logic [lkvt_pkg::IDX_W-1:0] rd_addr;
  logic [lkvt_pkg::CNT_W-1:0] last_idx;
  logic                       wr_key_en;
  logic                       wr_val_en;
  logic [lkvt_pkg::IDX_W-1:0] wr_addr;
  logic [lkvt_pkg::KEY_W-1:0] wr_key;
  logic [lkvt_pkg::VAL_W-1:0] wr_val;

  assign last_idx = count - lkvt_pkg::CNT_W'(1);
  assign rd_en    = cmd.scan_step | cmd.rd_last;
  assign rd_addr  = cmd.rd_last ? last_idx[lkvt_pkg::IDX_W-1:0]
                                : scan_idx[lkvt_pkg::IDX_W-1:0];

  always_comb begin
    wr_key_en = cmd.append | cmd.move_last;
    wr_val_en = cmd.append | cmd.move_last | cmd.wr_hit;
    wr_addr   = cmd.append ? count[lkvt_pkg::IDX_W-1:0] : chk_idx;
    wr_key    = cmd.move_last ? rd_key : req_key;
    wr_val    = cmd.move_last ? rd_val : req_value;
  end

  always_comb begin
    stat.kind     = req_kind;
    stat.hit      = chk_vld && (rd_key == req_key);
    stat.more     = (scan_idx < count);
    // capacity above the depth saturates at the depth
    stat.room     = (lkvt_pkg::CAP_W'(count) < cap) &&
                    (count < lkvt_pkg::CNT_W'(lkvt_pkg::DEPTH));
    stat.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (wr_key_en) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wr_val_en) begin
      val_mem[wr_addr] <= wr_val;
    end
    if (rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_val <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind  <= lkvt_pkg::kind_t'(in_kind);
      req_key   <= in_key;
      req_value <= in_value;
    end
    if (cmd.scan_step) begin
      chk_idx <= scan_idx[lkvt_pkg::IDX_W-1:0];
    end
    if (cmd.post) begin
      out_status      <= cmd.post_status;
      out_read_value  <= cmd.post_rd ? rd_val : '0;
      out_entry_count <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cap       <= lkvt_pkg::CAP_RESET;
      scan_idx  <= '0;
      chk_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
      if (cmd.load) begin
        scan_idx <= '0;
        chk_vld  <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_idx <= scan_idx + lkvt_pkg::CNT_W'(1);
        chk_vld  <= 1'b1;
      end
      priority if (cmd.clr) begin
        count <= '0;
      end else if (cmd.append) begin
        count <= count + lkvt_pkg::CNT_W'(1);
      end else if (cmd.move_last) begin
        count <= last_idx;
      end
      if (cmd.post) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/linear_key_value_table_top.sv
// channel  dir  handshake      payload
// req      in   valid/ready    kind, key, value
// rsp      out  valid/ready    status, read_value, entry_count
// cfg      in   cfg_we         cfg_wdata (capacity limit)
//
// one request at a time; the key store has a single read port and is scanned
// one slot per cycle; a remove that hits then reads the last entry and moves
// it into the hole of the removed one
// rst is synchronous and empties the table; the store itself is not cleared
// a new request is taken while the previous response still waits in rsp;
// the next response waits in the controller until rsp frees up
`timescale 1ns / 1ps
`default_nettype none

module linear_key_value_table_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  lkvt_req_if.sink                        req,
  lkvt_rsp_if.source                      rsp,
  input  wire logic                       cfg_we,
  input  wire logic [lkvt_pkg::CAP_W-1:0] cfg_wdata
);

  lkvt_pkg::dp_cmd_t  cmd;
  lkvt_pkg::dp_stat_t stat;

  lkvt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .valid (req.valid),
    .ready (req.ready),
    .stat  (stat),
    .cmd   (cmd)
  );

  lkvt_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (req.kind),
    .in_key          (req.key),
    .in_value        (req.value),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_status      (rsp.status),
    .out_read_value  (rsp.read_value),
    .out_entry_count (rsp.entry_count)
  );

`include "linear_key_value_table_top_assert.svh"

  // a response never overwrites one that has not been taken
  `LKVT_ASSERT_NOW(a_post_free, clk, rst, cmd.post, (!rsp.valid || rsp.ready), "response overrun")
  // the table never holds more entries than slots
  `LKVT_ASSERT_NOW(a_count_max, clk, rst, rsp.valid, (rsp.entry_count <= lkvt_pkg::CNT_W'(lkvt_pkg::DEPTH)), "entry count above depth")
  // an accepted request closes the input until its response is posted
  `LKVT_ASSERT_NEXT(a_one_req, clk, rst, (req.valid && req.ready), !req.ready, "second request taken")

endmodule

`default_nettype wire

// File: bench/linear_key_value_table_top_tb.sv
`timescale 1ns / 1ps

module linear_key_value_table_top_tb;
  import lkvt_pkg::*;

  typedef struct packed {
    kind_t            kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } table_req_t;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] entry_count;
  } table_rsp_t;

  localparam int LONG_HOLD = 120;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  lkvt_req_if req_ch ();
  lkvt_rsp_if rsp_ch ();

  linear_key_value_table_top dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // table model
  logic [KEY_W-1:0] tab_key [DEPTH];
  logic [VAL_W-1:0] tab_val [DEPTH];
  int               tab_count;
  logic [CAP_W-1:0] cap_limit;

  table_req_t pending_reqs [$];
  table_rsp_t expected_rsp [$];
  table_req_t cur_req;

  int          err_count;
  int          accepted_reqs;
  int          hold_done;
  int          hold_left;
  int          tx_gap;
  int          rx_gap;
  bit          idle_on;
  bit          calm;
  int          n_done;
  int          n_hit;
  int          n_miss;
  int          n_full;
  int          n_clear;
  logic [CAP_W-1:0] rand_cap;

  function automatic table_rsp_t apply_request(input table_req_t r);
    table_rsp_t o;
    int         slot;
    int         i;
    int         eff_cap;
    o = '{status: ST_OK, read_value: '0, entry_count: '0};
    slot = -1;
    eff_cap = (cap_limit > DEPTH) ? DEPTH : cap_limit;
    for (i = 0; i < tab_count; i++)
      if (slot < 0 && tab_key[i] == r.key) slot = i;
    case (r.kind)
      KIND_GET: begin
        if (slot >= 0) o.read_value = tab_val[slot];
        else o.status = ST_NOT_FOUND;
      end
      KIND_SET: begin
        if (slot >= 0) begin
          tab_val[slot] = r.value;
        end else if (tab_count < eff_cap && tab_count < DEPTH) begin
          tab_key[tab_count] = r.key;
          tab_val[tab_count] = r.value;
          tab_count++;
        end else begin
          o.status = ST_FULL;
        end
      end
      KIND_REMOVE: begin
        // last entry fills the hole
        if (slot >= 0) begin
          tab_key[slot] = tab_key[tab_count-1];
          tab_val[slot] = tab_val[tab_count-1];
          tab_count--;
        end else begin
          o.status = ST_NOT_FOUND;
        end
      end
      default: tab_count = 0;
    endcase
    o.entry_count = CNT_W'(tab_count);
    return o;
  endfunction

  task automatic note_error(input string msg);
    if (err_count < 10) $display("mismatch: %s", msg);
    err_count++;
  endtask

  task automatic queue_item(input kind_t kind, input logic [KEY_W-1:0] key,
                            input logic [VAL_W-1:0] value);
    table_req_t r;
    r.kind = kind;
    r.key = key;
    r.value = value;
    pending_reqs.push_back(r);
  endtask

  // mostly keys from a small pool so gets and removes hit, some stray keys
  task automatic queue_random(input int n, input int pool_n, input int clear_pct);
    logic [KEY_W-1:0] pool [$];
    int               roll;
    kind_t            kind;
    pool = {};
    repeat (pool_n) begin
      if ($urandom_range(0, 9) == 0)
        pool.push_back($urandom_range(0, 1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}});
      else
        pool.push_back($urandom());
    end
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < clear_pct) kind = KIND_CLEAR;
      else if (roll < 36) kind = KIND_GET;
      else if (roll < 76) kind = KIND_SET;
      else kind = KIND_REMOVE;
      if ($urandom_range(0, 9) == 0)
        queue_item(kind, $urandom(), $urandom());
      else
        queue_item(kind, pool[$urandom_range(0, pool_n - 1)], $urandom());
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_ch.valid || expected_rsp.size() != 0)
      @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    @(posedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_limit = v;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int n, input int pool_n,
                           input int clear_pct, input bit idles);
    write_capacity(cap);
    idle_on = idles;
    queue_random(n, pool_n, clear_pct);
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_GET;
    req_ch.key = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_rsp.push_back(apply_request(cur_req));
        accepted_reqs <= accepted_reqs + 1;
        if (cur_req.kind == KIND_CLEAR) n_clear++;
      end
      if (req_ch.valid && !req_ch.ready) begin
        // hold the offered request
      end else if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() != 0 && idle_on && !calm &&
                   $urandom_range(0, 4) == 0) begin
        tx_gap <= $urandom_range(0, 3);
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        cur_req = pending_reqs.pop_front();
        req_ch.kind <= cur_req.kind;
        req_ch.key <= cur_req.key;
        req_ch.value <= cur_req.value;
        req_ch.valid <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-offs so the block backs up into the request side
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((hold_done == 0 && accepted_reqs >= 300) ||
                 (hold_done == 1 && accepted_reqs >= 1100)) begin
      hold_left <= LONG_HOLD;
      hold_done <= hold_done + 1;
    end
  end

  // response monitor
  always @(posedge clk) begin
    table_rsp_t exp_rsp;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsp.size() == 0) begin
          note_error($sformatf("unexpected response status %0d value %h count %0d",
                               rsp_ch.status, rsp_ch.read_value, rsp_ch.entry_count));
        end else begin
          exp_rsp = expected_rsp.pop_front();
          if (rsp_ch.status !== exp_rsp.status ||
              rsp_ch.read_value !== exp_rsp.read_value ||
              rsp_ch.entry_count !== exp_rsp.entry_count)
            note_error($sformatf({"response %0d: expected status %0d value %h count %0d,",
                                  " got status %0d value %h count %0d"},
                                 n_done, exp_rsp.status, exp_rsp.read_value,
                                 exp_rsp.entry_count, rsp_ch.status,
                                 rsp_ch.read_value, rsp_ch.entry_count));
          case (exp_rsp.status)
            ST_NOT_FOUND: n_miss++;
            ST_FULL: n_full++;
            default: if (exp_rsp.read_value != '0) n_hit++;
          endcase
        end
        n_done++;
      end
      if (hold_left != 0) begin
        rsp_ch.ready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap <= rx_gap - 1;
        rsp_ch.ready <= 1'b0;
      end else if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
        rx_gap <= $urandom_range(0, 3);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    tab_count = 0;
    cap_limit = CAP_RESET;
    err_count = 0;
    accepted_reqs = 0;
    hold_done = 0;
    hold_left = 0;
    tx_gap = 0;
    rx_gap = 0;
    idle_on = 1'b1;
    calm = 1'b0;
    n_done = 0;
    n_hit = 0;
    n_miss = 0;
    n_full = 0;
    n_clear = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty table, extreme keys and values, overwrite, remove with move, clear
    queue_item(KIND_GET, 32'h0000_0000, 32'h0000_0000);
    queue_item(KIND_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_item(KIND_SET, 32'h0000_0000, 32'h0000_0000);
    queue_item(KIND_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(KIND_SET, 32'h1234_5678, 32'hA5A5_A5A5);
    queue_item(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_item(KIND_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_item(KIND_SET, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_item(KIND_GET, 32'h0000_0000, 32'h0000_0000);
    queue_item(KIND_GET, 32'h5555_5555, 32'h0000_0000);
    queue_item(KIND_REMOVE, 32'h0000_0000, 32'h0000_0000);
    queue_item(KIND_GET, 32'h1234_5678, 32'h0000_0000);
    queue_item(KIND_REMOVE, 32'h0000_9999, 32'h0000_0000);
    queue_item(KIND_REMOVE, 32'h1234_5678, 32'h0000_0000);
    queue_item(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_item(KIND_CLEAR, 32'h0000_0000, 32'h0000_0000);
    queue_item(KIND_SET, 32'hAAAA_AAAA, 32'h0000_0001);
    wait_drained();

    // capacity one, then zero with an entry still stored
    write_capacity(CAP_W'(1));
    queue_item(KIND_SET, 32'h5555_5555, 32'h0000_0002);
    queue_item(KIND_SET, 32'hAAAA_AAAA, 32'h0000_0003);
    wait_drained();
    write_capacity(CAP_W'(0));
    queue_item(KIND_SET, 32'h5555_5555, 32'h0000_0004);
    queue_item(KIND_SET, 32'hAAAA_AAAA, 32'h8000_0004);
    queue_item(KIND_GET, 32'hAAAA_AAAA, 32'h0000_0000);
    queue_item(KIND_REMOVE, 32'hAAAA_AAAA, 32'h0000_0000);
    queue_item(KIND_SET, 32'hAAAA_AAAA, 32'h0000_0005);
    wait_drained();

    run_phase(CAP_W'(31), 250, 40, 0, 1'b1);
    run_phase(CAP_W'(0), 200, 24, 2, 1'b1);
    run_phase(CAP_W'(1), 200, 6, 3, 1'b1);
    run_phase(CAP_W'(16), 250, 12, 3, 1'b0);
    run_phase(CAP_W'(5), 250, 10, 4, 1'b1);
    run_phase(CAP_W'(17), 250, 30, 1, 1'b1);
    rand_cap = CAP_W'($urandom_range(2, 15));
    run_phase(rand_cap, 250, 20, 3, 1'b1);
    calm = 1'b1;
    run_phase(CAP_W'(16), 200, 16, 3, 1'b1);

    $display("covered %0d requests: %0d get hits with data, %0d not found, %0d table full,",
             n_done, n_hit, n_miss, n_full);
    $display("%0d clears, capacity limits 31, 0, 1, 16, 5, 17 and %0d, two long stalls",
             n_clear, rand_cap);
    if (err_count == 0 && expected_rsp.size() == 0) begin
      $display("[linear_key_value_table_top] OK");
    end else begin
      $display("[linear_key_value_table_top] ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[linear_key_value_table_top] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/lkvt_pkg.sv
hw/rtl/lkvt_req_if.sv
hw/rtl/lkvt_rsp_if.sv
hw/rtl/lkvt_ctrl.sv
hw/rtl/lkvt_dpath.sv
hw/rtl/linear_key_value_table_top.sv
bench/linear_key_value_table_top_tb.sv
